[rtl/core/bdq_pkg.sv]
package bdq_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int DATA_W = 32;
   localparam int POS_W  = 6;
   localparam int CMD_W  = 3;
   localparam int STAT_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_POP_BACK   = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_READ       = 3'd4,
      CMD_WRITE      = 3'd5,
      CMD_DEDUP      = 3'd6
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic exec;
      logic dd_prime;
      logic dd_scan;
      logic load_rsp;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic dd_start;
      logic dd_last;
   } dp_status_type;

endpackage

[rtl/core/bdq_ctrl.sv]
module bdq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  bdq_pkg::dp_status_type dp_status,
   output bdq_pkg::ctrl_cmd_type  dp_cmd
);

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_EXEC     = 5'b00010,
      S_DD_PRIME = 5'b00100,
      S_DD_SCAN  = 5'b01000,
      S_FIN      = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      dp_cmd     = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               dp_cmd.load_req = 1'b1;
               state_in        = S_EXEC;
            end
         end
         S_EXEC: begin
            dp_cmd.exec = 1'b1;
            state_in    = dp_status.dd_start ? S_DD_PRIME : S_FIN;
         end
         S_DD_PRIME: begin
            dp_cmd.dd_prime = 1'b1;
            state_in        = S_DD_SCAN;
         end
         S_DD_SCAN: begin
            dp_cmd.dd_scan = 1'b1;
            if (dp_status.dd_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // result goes out and the next word may enter in the same cycle
            if (out_free) begin
               dp_cmd.load_rsp = 1'b1;
               req_tready      = 1'b1;
               if (req_tvalid) begin
                  dp_cmd.load_req = 1'b1;
                  state_in        = S_EXEC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (dp_cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/core/bdq_datapath.sv]
module bdq_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [bdq_pkg::CMD_W-1:0]         req_command,
   input  logic signed [bdq_pkg::DATA_W-1:0] req_item_value,
   input  logic [bdq_pkg::POS_W-1:0]         req_position,
   output logic signed [bdq_pkg::DATA_W-1:0] rsp_read_value,
   output logic [bdq_pkg::CNT_W-1:0]         rsp_element_count,
   output logic [bdq_pkg::STAT_W-1:0]        rsp_status,
   input  bdq_pkg::ctrl_cmd_type             dp_cmd,
   output bdq_pkg::dp_status_type            dp_status
);

   logic [bdq_pkg::DATA_W-1:0] mem [bdq_pkg::DEPTH];

   bdq_pkg::cmd_type            cmd_ff;
   logic [bdq_pkg::DATA_W-1:0]  val_ff;
   logic [bdq_pkg::POS_W-1:0]   pos_ff;

   logic [bdq_pkg::ADDR_W-1:0]  fp_ff, fp_in;
   logic [bdq_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   bdq_pkg::status_type         st_ff, st_in;
   logic                        rdsel_ff, rdsel_in;
   logic [bdq_pkg::ADDR_W-1:0]  w_ff, w_in;
   logic [bdq_pkg::CNT_W-1:0]   i_ff, i_in;
   logic [bdq_pkg::DATA_W-1:0]  last_ff, last_in;
   logic [bdq_pkg::DATA_W-1:0]  rdata_ff;

   logic [bdq_pkg::DATA_W-1:0]  rsp_value_ff;
   logic [bdq_pkg::CNT_W-1:0]   rsp_count_ff;
   logic [bdq_pkg::STAT_W-1:0]  rsp_status_ff;

   logic                        we, re;
   logic [bdq_pkg::ADDR_W-1:0]  waddr, raddr;
   logic [bdq_pkg::DATA_W-1:0]  wdata;

   logic                        full, empty, out_of_range, differ;
   logic [bdq_pkg::ADDR_W-1:0]  w_next;

   assign full         = (cnt_ff == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
   assign empty        = (cnt_ff == '0);
   assign out_of_range = (bdq_pkg::CNT_W'(pos_ff) >= cnt_ff);
   assign differ       = (rdata_ff != last_ff);
   assign w_next       = differ ? w_ff + 1'b1 : w_ff;

   // the controller only looks at these in the states where they matter
   assign dp_status.dd_start = (cmd_ff == bdq_pkg::CMD_DEDUP) &&
                               (cnt_ff > bdq_pkg::CNT_W'(1));
   assign dp_status.dd_last  = (i_ff == cnt_ff);

   always_comb begin
      fp_in    = fp_ff;
      cnt_in   = cnt_ff;
      st_in    = st_ff;
      rdsel_in = rdsel_ff;
      w_in     = w_ff;
      i_in     = i_ff;
      last_in  = last_ff;
      we       = 1'b0;
      re       = 1'b0;
      waddr    = fp_ff;
      raddr    = fp_ff;
      wdata    = val_ff;
      if (dp_cmd.exec) begin
         st_in    = bdq_pkg::ST_OK;
         rdsel_in = 1'b0;
         case (cmd_ff)
            bdq_pkg::CMD_PUSH_BACK: begin
               if (full) begin
                  st_in = bdq_pkg::ST_FULL;
               end else begin
                  we     = 1'b1;
                  waddr  = fp_ff + cnt_ff[bdq_pkg::ADDR_W-1:0];
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            bdq_pkg::CMD_PUSH_FRONT: begin
               if (full) begin
                  st_in = bdq_pkg::ST_FULL;
               end else begin
                  we     = 1'b1;
                  waddr  = fp_ff - 1'b1;
                  fp_in  = fp_ff - 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            bdq_pkg::CMD_POP_BACK: begin
               if (empty) begin
                  st_in = bdq_pkg::ST_EMPTY;
               end else begin
                  re       = 1'b1;
                  cnt_in   = cnt_ff - 1'b1;
                  raddr    = fp_ff + cnt_in[bdq_pkg::ADDR_W-1:0];
                  rdsel_in = 1'b1;
               end
            end
            bdq_pkg::CMD_POP_FRONT: begin
               if (empty) begin
                  st_in = bdq_pkg::ST_EMPTY;
               end else begin
                  re       = 1'b1;
                  raddr    = fp_ff;
                  fp_in    = fp_ff + 1'b1;
                  cnt_in   = cnt_ff - 1'b1;
                  rdsel_in = 1'b1;
               end
            end
            bdq_pkg::CMD_READ: begin
               if (out_of_range) begin
                  st_in = bdq_pkg::ST_RANGE;
               end else begin
                  re       = 1'b1;
                  raddr    = fp_ff + bdq_pkg::ADDR_W'(pos_ff);
                  rdsel_in = 1'b1;
               end
            end
            bdq_pkg::CMD_WRITE: begin
               if (out_of_range) begin
                  st_in = bdq_pkg::ST_RANGE;
               end else begin
                  we    = 1'b1;
                  waddr = fp_ff + bdq_pkg::ADDR_W'(pos_ff);
               end
            end
            bdq_pkg::CMD_DEDUP: begin
               // primes the read of element 0; with fewer than two elements the controller skips the compaction
               re    = 1'b1;
               raddr = fp_ff;
               w_in  = '0;
               i_in  = bdq_pkg::CNT_W'(1);
            end
            default: ;
         endcase
      end else if (dp_cmd.dd_prime) begin
         last_in = rdata_ff;
         re      = 1'b1;
         raddr   = fp_ff + i_ff[bdq_pkg::ADDR_W-1:0];
         i_in    = i_ff + 1'b1;
      end else if (dp_cmd.dd_scan) begin
         // rdata holds element i-1; survivors are packed at w and below
         w_in = w_next;
         if (differ) begin
            we      = 1'b1;
            waddr   = fp_ff + w_next;
            wdata   = rdata_ff;
            last_in = rdata_ff;
         end
         if (i_ff == cnt_ff) begin
            cnt_in = bdq_pkg::CNT_W'(w_next) + 1'b1;
         end else begin
            re    = 1'b1;
            raddr = fp_ff + i_ff[bdq_pkg::ADDR_W-1:0];
            i_in  = i_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         fp_ff  <= fp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_req) begin
         cmd_ff <= bdq_pkg::cmd_type'(req_command);
         val_ff <= req_item_value;
         pos_ff <= req_position;
      end
      st_ff    <= st_in;
      rdsel_ff <= rdsel_in;
      w_ff     <= w_in;
      i_ff     <= i_in;
      last_ff  <= last_in;
      if (dp_cmd.load_rsp) begin
         rsp_value_ff  <= rdsel_ff ? rdata_ff : '0;
         rsp_count_ff  <= cnt_ff;
         rsp_status_ff <= st_ff;
      end
   end

   assign rsp_read_value    = rsp_value_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

[rtl/core/bounded_deque_with_dedup_top.sv]
// bounded double-ended store of 64 signed 32-bit words, kept as a ring
// with a front pointer and a count
// req channel: one word per command; req_tuser carries the command code,
// req_tdata the value and the position; rsp channel: exactly one word per
// command with the value read or popped, the new count and a status
// a word accepted in S_IDLE or S_FIN is executed in S_EXEC and its result is
// loaded into the output register from S_FIN; dedup of two or more elements
// passes through S_DD_PRIME and S_DD_SCAN before S_FIN, walking the live
// elements one per cycle through the single write and single read port of the element memory
// a new command is not accepted while one is in flight; the next command
// is accepted in the cycle its predecessor's result is loaded into the
// output register
// when rsp_tready is low the finished result waits in the output register
// while the next command is accepted and executed; its result is held
// back until the register frees up
// reset (synchronous, active high) empties the store at once; memory
// contents are left as they are and are never returned before written
module bounded_deque_with_dedup_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // item_value[31:0], position[37:32], zero fill
   input  logic [2:0]  req_tuser,   // command[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // read_value[31:0], element_count[38:32], zero fill
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   bdq_pkg::ctrl_cmd_type  dp_cmd;
   bdq_pkg::dp_status_type dp_status;

   logic signed [bdq_pkg::DATA_W-1:0] rsp_read_value;
   logic [bdq_pkg::CNT_W-1:0]         rsp_element_count;
   logic [bdq_pkg::STAT_W-1:0]        rsp_status;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   bdq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_command       (req_tuser),
      .req_item_value    (req_tdata[31:0]),
      .req_position      (req_tdata[37:32]),
      .rsp_read_value    (rsp_read_value),
      .rsp_element_count (rsp_element_count),
      .rsp_status        (rsp_status),
      .dp_cmd            (dp_cmd),
      .dp_status         (dp_status)
   );

   assign rsp_tdata = {1'b0, rsp_element_count, rsp_read_value};
   assign rsp_tuser = rsp_status;

endmodule

[rtl/core/bdq_checker.sv]
module bdq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[38:32] <= 7'(bdq_pkg::DEPTH))
      else $error("element count above depth");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == bdq_pkg::ST_FULL |->
         rsp_tdata[38:32] == 7'(bdq_pkg::DEPTH) && rsp_tdata[31:0] == '0)
      else $error("full status without a full store");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == bdq_pkg::ST_EMPTY |->
         rsp_tdata[38:32] == '0 && rsp_tdata[31:0] == '0)
      else $error("empty status without an empty store");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

endmodule

bind bounded_deque_with_dedup_top bdq_checker u_bdq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[verif/bounded_deque_with_dedup_top_tb.sv]
module bounded_deque_with_dedup_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [bdq_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 3 * bdq_pkg::DEPTH;
   localparam int PHASE_WORDS    = 220;

   typedef struct {
      logic [bdq_pkg::DATA_W-1:0] read_value;
      logic [bdq_pkg::CNT_W-1:0]  count;
      bdq_pkg::status_type        status;
   } deque_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // item_value[31:0], position[37:32], zero fill
   logic [2:0]  req_tuser = '0;   // command[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // read_value[31:0], element_count[38:32], zero fill
   logic [1:0]  rsp_tuser;        // status[1:0]

   // shadow copy of the ring
   logic [bdq_pkg::DATA_W-1:0] shadow_store [bdq_pkg::DEPTH];
   logic [bdq_pkg::ADDR_W-1:0] shadow_front = '0;
   logic [bdq_pkg::CNT_W-1:0]  shadow_count = '0;

   deque_result_type pending_results[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;
   int words_sent     = 0;
   int results_checked = 0;
   int dedup_words    = 0;
   int full_hits      = 0;
   int empty_hits     = 0;
   int range_hits     = 0;
   int stall_cycles   = 0;

   bounded_deque_with_dedup_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   function automatic logic [bdq_pkg::ADDR_W-1:0] ring_slot(
         input logic [bdq_pkg::CNT_W-1:0] idx);
      return shadow_front + idx[bdq_pkg::ADDR_W-1:0];
   endfunction

   // applies one command to the shadow ring and returns what the block must answer
   function automatic deque_result_type apply_deque_cmd(
         input logic [bdq_pkg::CMD_W-1:0]  cmd,
         input logic [bdq_pkg::DATA_W-1:0] value,
         input logic [bdq_pkg::POS_W-1:0]  pos);
      deque_result_type r;
      logic [bdq_pkg::CNT_W-1:0]  keep;
      logic [bdq_pkg::DATA_W-1:0] v;
      r.read_value = '0;
      r.status     = bdq_pkg::ST_OK;
      case (cmd)
         bdq_pkg::CMD_PUSH_BACK: begin
            if (shadow_count == bdq_pkg::CNT_W'(bdq_pkg::DEPTH)) begin
               r.status = bdq_pkg::ST_FULL;
            end else begin
               shadow_store[ring_slot(shadow_count)] = value;
               shadow_count++;
            end
         end
         bdq_pkg::CMD_PUSH_FRONT: begin
            if (shadow_count == bdq_pkg::CNT_W'(bdq_pkg::DEPTH)) begin
               r.status = bdq_pkg::ST_FULL;
            end else begin
               shadow_front--;
               shadow_store[shadow_front] = value;
               shadow_count++;
            end
         end
         bdq_pkg::CMD_POP_BACK: begin
            if (shadow_count == '0) begin
               r.status = bdq_pkg::ST_EMPTY;
            end else begin
               shadow_count--;
               r.read_value = shadow_store[ring_slot(shadow_count)];
            end
         end
         bdq_pkg::CMD_POP_FRONT: begin
            if (shadow_count == '0) begin
               r.status = bdq_pkg::ST_EMPTY;
            end else begin
               r.read_value = shadow_store[shadow_front];
               shadow_front++;
               shadow_count--;
            end
         end
         bdq_pkg::CMD_READ: begin
            if (bdq_pkg::CNT_W'(pos) >= shadow_count) r.status = bdq_pkg::ST_RANGE;
            else r.read_value = shadow_store[ring_slot(bdq_pkg::CNT_W'(pos))];
         end
         bdq_pkg::CMD_WRITE: begin
            if (bdq_pkg::CNT_W'(pos) >= shadow_count) r.status = bdq_pkg::ST_RANGE;
            else shadow_store[ring_slot(bdq_pkg::CNT_W'(pos))] = value;
         end
         bdq_pkg::CMD_DEDUP: begin
            if (shadow_count != '0) begin
               keep = '0;
               for (int i = 1; i < int'(shadow_count); i++) begin
                  v = shadow_store[ring_slot(bdq_pkg::CNT_W'(i))];
                  if (v != shadow_store[ring_slot(keep)]) begin
                     keep++;
                     shadow_store[ring_slot(keep)] = v;
                  end
               end
               shadow_count = keep + 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.count = shadow_count;
      case (r.status)
         bdq_pkg::ST_FULL:  full_hits++;
         bdq_pkg::ST_EMPTY: empty_hits++;
         bdq_pkg::ST_RANGE: range_hits++;
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch in %s at result %0d: got %0h, expected %0h",
               what, results_checked, got, want);
      error_count++;
   endtask

   task automatic send_word(input logic [bdq_pkg::CMD_W-1:0]  cmd,
                            input logic [bdq_pkg::DATA_W-1:0] value,
                            input logic [bdq_pkg::POS_W-1:0]  pos);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, pos, value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(apply_deque_cmd(cmd, value, pos));
      words_sent++;
      if (cmd == bdq_pkg::CMD_DEDUP) dedup_words++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // result side: random stalls, each accepted word checked against the oldest prediction
   always @(posedge clock) begin
      deque_result_type want;
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata[31:0], '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[31:0] !== want.read_value)
               report_mismatch("read_value", rsp_tdata[31:0], want.read_value);
            if (rsp_tdata[38:32] !== want.count)
               report_mismatch("element_count", 32'(rsp_tdata[38:32]), 32'(want.count));
            if (rsp_tuser !== want.status)
               report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
         end
         results_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                  stall_cycles, pending_results.size());
         $display("FAILURE");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic logic [bdq_pkg::DATA_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) return $urandom();
      if (sel < 7) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return 32'h0000_0000;
         endcase
      end
      // tiny pool so neighbors often match
      return $urandom_range(0, 2);
   endfunction

   function automatic logic [bdq_pkg::CMD_W-1:0] pick_push();
      return $urandom_range(0, 1) ? bdq_pkg::CMD_PUSH_FRONT : bdq_pkg::CMD_PUSH_BACK;
   endfunction

   function automatic logic [bdq_pkg::CMD_W-1:0] pick_pop();
      return $urandom_range(0, 1) ? bdq_pkg::CMD_POP_FRONT : bdq_pkg::CMD_POP_BACK;
   endfunction

   function automatic logic [bdq_pkg::POS_W-1:0] any_pos();
      return bdq_pkg::POS_W'($urandom_range(0, 63));
   endfunction

   function automatic logic [bdq_pkg::POS_W-1:0] pick_pos();
      if (shadow_count != '0 && $urandom_range(0, 3) != 0)
         return bdq_pkg::POS_W'($urandom_range(0, int'(shadow_count) - 1));
      return any_pos();
   endfunction

   task automatic test_empty_store();
      send_word(bdq_pkg::CMD_POP_BACK, 32'h1234_5678, 6'd0);
      send_word(bdq_pkg::CMD_POP_FRONT, 32'h0, 6'd0);
      send_word(bdq_pkg::CMD_READ, 32'h0, 6'd0);
      send_word(bdq_pkg::CMD_WRITE, 32'hdead_beef, 6'd63);
      send_word(bdq_pkg::CMD_DEDUP, 32'h0, 6'd0);
      send_word(CMD_UNUSED, 32'hffff_ffff, 6'd63);
   endtask

   task automatic test_end_pushes();
      // builds 0, 8000_0000, 7fff_ffff, ffff_ffff
      send_word(bdq_pkg::CMD_PUSH_BACK, 32'h7fff_ffff, 6'd0);
      send_word(bdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 6'd63);
      send_word(bdq_pkg::CMD_PUSH_BACK, 32'hffff_ffff, 6'd0);
      send_word(bdq_pkg::CMD_PUSH_FRONT, 32'h0000_0000, 6'd0);
      send_word(bdq_pkg::CMD_READ, 32'h0, 6'd0);
      send_word(bdq_pkg::CMD_READ, 32'h0, 6'd3);
      send_word(bdq_pkg::CMD_READ, 32'h0, 6'd4);
      send_word(bdq_pkg::CMD_READ, 32'h0, 6'd63);
      send_word(bdq_pkg::CMD_WRITE, 32'hffff_ffff, 6'd2);
      send_word(bdq_pkg::CMD_WRITE, 32'h5555_aaaa, 6'd63);
      send_word(CMD_UNUSED, 32'h0, 6'd0);
   endtask

   task automatic test_dedup_runs();
      send_word(bdq_pkg::CMD_PUSH_BACK, 32'h0, 6'd0);
      send_word(bdq_pkg::CMD_PUSH_BACK, 32'h0, 6'd0);
      send_word(bdq_pkg::CMD_DEDUP, 32'h0, 6'd0);
      send_word(bdq_pkg::CMD_READ, 32'h0, 6'd3);
      send_word(bdq_pkg::CMD_POP_BACK, 32'h0, 6'd0);
      send_word(bdq_pkg::CMD_POP_FRONT, 32'h0, 6'd0);
   endtask

   task automatic run_mixed_traffic(input int target);
      int start;
      int sel;
      logic [bdq_pkg::DATA_W-1:0] v;
      start = words_sent;
      while (words_sent - start < target) begin
         sel = $urandom_range(0, 99);
         if (sel < 12) begin
            // fill to the top, then one push too many
            while (shadow_count < bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
               send_word(pick_push(), pick_value(), any_pos());
            send_word(pick_push(), pick_value(), any_pos());
         end else if (sel < 24) begin
            while (shadow_count != '0) send_word(pick_pop(), $urandom(), any_pos());
            send_word(pick_pop(), $urandom(), any_pos());
         end else if (sel < 50) begin
            // runs of equal words, then compact
            repeat ($urandom_range(2, 6)) begin
               v = pick_value();
               repeat ($urandom_range(1, 4)) send_word(pick_push(), v, any_pos());
            end
            if ($urandom_range(0, 1)) send_word(bdq_pkg::CMD_WRITE, v, pick_pos());
            send_word(bdq_pkg::CMD_DEDUP, $urandom(), any_pos());
         end else if (sel < 90) begin
            repeat ($urandom_range(1, 8)) begin
               sel = $urandom_range(0, 99);
               if (sel < 28) send_word(pick_push(), pick_value(), any_pos());
               else if (sel < 48) send_word(pick_pop(), $urandom(), any_pos());
               else if (sel < 70) send_word(bdq_pkg::CMD_READ, $urandom(), pick_pos());
               else if (sel < 92) send_word(bdq_pkg::CMD_WRITE, pick_value(), pick_pos());
               else send_word(bdq_pkg::CMD_DEDUP, $urandom(), any_pos());
            end
         end else begin
            repeat ($urandom_range(1, 3))
               send_word(bdq_pkg::CMD_W'($urandom_range(0, 7)), $urandom(), any_pos());
         end
      end
   endtask

   task automatic test_random_traffic();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_mixed_traffic(PHASE_WORDS);
      // hold off until the block has answered everything
      wait_drained();
      send_idle_pct = 46;
      run_mixed_traffic(PHASE_WORDS);
      send_idle_pct  = 0;
      recv_stall_pct = 46;
      run_mixed_traffic(PHASE_WORDS);
      send_idle_pct  = 13;
      recv_stall_pct = 13;
      run_mixed_traffic(PHASE_WORDS);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_store();
      test_end_pushes();
      test_dedup_runs();
      test_random_traffic();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d commands (%0d dedup), checked %0d results", words_sent, dedup_words,
               results_checked);
      $display("flagged: %0d full, %0d empty, %0d out of range; idle mixes none/46/46/13",
               full_hits, empty_hits, range_hits);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d results never arrived", error_count,
                  pending_results.size());
         $display("FAILURE");
      end
      $finish;
   end

endmodule
